// ===== rtl/core/indexed_list_store_unit_macros.svh =====
// assertion macros for the indexed list store unit
// used by the controller and datapath modules, expects clk and rst_n in scope
`ifndef INDEXED_LIST_STORE_UNIT_MACROS_SVH
`define INDEXED_LIST_STORE_UNIT_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define ILSU_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define ILSU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/ilsu_pkg.sv =====
// shared constants, payload structs and control types for the list store unit
// no dependencies; used by every module of the block except ilsu_ram
package ilsu_pkg;

  // list sizing
  localparam int CAPACITY   = 64;
  localparam int ITEM_WIDTH = 32;
  localparam int ADDR_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int IDX_W      = 6;
  localparam int CMP_W      = (CNT_W > IDX_W) ? CNT_W : IDX_W;
  localparam int WORD_W     = 32;
  localparam int CNT_FLD_W  = 7;

  typedef logic [ITEM_WIDTH-1:0] item_t;
  typedef logic [ADDR_W-1:0]     addr_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [CMP_W-1:0]      cmp_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [WORD_W-1:0]     word_t;
  typedef logic [CNT_FLD_W-1:0]  cnt_fld_t;

  // operation codes
  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_READ   = 2'd2,
    CMD_WRITE  = 2'd3
  } cmd_t;

  // result status codes
  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_BAD_INDEX = 2'd1,
    STS_FULL      = 2'd2
  } status_t;

  typedef struct packed {
    cmd_t  command;
    idx_t  index;
    word_t value;
  } in_item_t;

  typedef struct packed {
    word_t    read_value;
    cnt_fld_t item_count;
    status_t  status;
  } out_item_t;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_RDWAIT,
    S_RMWAIT,
    S_SHIFT,
    S_DONE
  } state_t;

  // memory read address select
  typedef enum logic [1:0] {
    RD_NONE,
    RD_INDEX,
    RD_PTR1,
    RD_PTR2
  } rd_sel_t;

  // memory write address and data select
  typedef enum logic [1:0] {
    WR_NONE,
    WR_APPEND,
    WR_INDEX,
    WR_SHIFT
  } wr_sel_t;

  // controller to datapath commands
  typedef struct packed {
    logic    capture;
    wr_sel_t wr_sel;
    rd_sel_t rd_sel;
    logic    ptr_load;
    logic    ptr_inc;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    rd_capture;
    logic    rd_clear;
    logic    res_set;
    status_t res_status;
    logic    out_load;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    cmd_t command;
    logic idx_ok;
    logic full;
    logic more1;
    logic more2;
  } dp_stat_t;

endpackage

// ===== rtl/core/ilsu_ram.sv =====
// generic single write port, single read port ram with registered read data
// no dependencies
module ilsu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/ilsu_datapath.sv =====
// datapath of the list store: captured transaction, count, shift pointer, item ram
// depends on ilsu_pkg, ilsu_ram and the assertion macro header
`include "indexed_list_store_unit_macros.svh"

module ilsu_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  ilsu_pkg::in_item_t  in_data,
  input  ilsu_pkg::dp_cmd_t   cmd,
  output ilsu_pkg::dp_stat_t  stat,
  output ilsu_pkg::out_item_t out_data
);

  ilsu_pkg::cmd_t      cmd_r,    cmd_nxt;
  ilsu_pkg::idx_t      idx_r,    idx_nxt;
  ilsu_pkg::item_t     val_r,    val_nxt;
  ilsu_pkg::cnt_t      count_r,  count_nxt;
  ilsu_pkg::addr_t     ptr_r,    ptr_nxt;
  ilsu_pkg::item_t     rd_r,     rd_nxt;
  ilsu_pkg::status_t   sts_r,    sts_nxt;
  ilsu_pkg::out_item_t out_r,    out_nxt;

  ilsu_pkg::cnt_t  ptr_ext;
  ilsu_pkg::cnt_t  ptr_p1;
  ilsu_pkg::cnt_t  ptr_p2;
  logic            ram_we;
  ilsu_pkg::addr_t ram_waddr;
  ilsu_pkg::item_t ram_wdata;
  logic            ram_re;
  ilsu_pkg::addr_t ram_raddr;
  ilsu_pkg::item_t ram_rdata;

  // pointer arithmetic for the shift
  assign ptr_ext = ilsu_pkg::cnt_t'(ptr_r);
  assign ptr_p1  = ptr_ext + ilsu_pkg::cnt_t'(1);
  assign ptr_p2  = ptr_ext + ilsu_pkg::cnt_t'(2);

  // status back to the controller
  assign stat.command = cmd_r;
  assign stat.idx_ok  = ilsu_pkg::cmp_t'(idx_r) < ilsu_pkg::cmp_t'(count_r);
  assign stat.full    = count_r == ilsu_pkg::cnt_t'(ilsu_pkg::CAPACITY);
  assign stat.more1   = ptr_p1 < count_r;
  assign stat.more2   = ptr_p2 < count_r;

  // ram write select
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ptr_r;
    ram_wdata = ram_rdata;
    case (cmd.wr_sel)
      ilsu_pkg::WR_APPEND: begin
        ram_we    = 1'b1;
        ram_waddr = ilsu_pkg::addr_t'(count_r);
        ram_wdata = val_r;
      end
      ilsu_pkg::WR_INDEX: begin
        ram_we    = 1'b1;
        ram_waddr = ilsu_pkg::addr_t'(idx_r);
        ram_wdata = val_r;
      end
      ilsu_pkg::WR_SHIFT: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_r;
        ram_wdata = ram_rdata;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // ram read select
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = ptr_r;
    case (cmd.rd_sel)
      ilsu_pkg::RD_INDEX: begin
        ram_re    = 1'b1;
        ram_raddr = ilsu_pkg::addr_t'(idx_r);
      end
      ilsu_pkg::RD_PTR1: begin
        ram_re    = 1'b1;
        ram_raddr = ilsu_pkg::addr_t'(ptr_p1);
      end
      ilsu_pkg::RD_PTR2: begin
        ram_re    = 1'b1;
        ram_raddr = ilsu_pkg::addr_t'(ptr_p2);
      end
      default: begin
        ram_re = 1'b0;
      end
    endcase
  end

  ilsu_ram #(
    .WIDTH (ilsu_pkg::ITEM_WIDTH),
    .DEPTH (ilsu_pkg::CAPACITY)
  ) u_item_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // transaction capture
  always_comb begin
    cmd_nxt = cmd_r;
    idx_nxt = idx_r;
    val_nxt = val_r;
    if (cmd.capture) begin
      cmd_nxt = in_data.command;
      idx_nxt = in_data.index;
      val_nxt = ilsu_pkg::item_t'(in_data.value);
    end
  end

  // item count
  always_comb begin
    count_nxt = count_r;
    if (cmd.cnt_inc) begin
      count_nxt = count_r + ilsu_pkg::cnt_t'(1);
    end else if (cmd.cnt_dec) begin
      count_nxt = count_r - ilsu_pkg::cnt_t'(1);
    end
  end

  // shift pointer
  always_comb begin
    ptr_nxt = ptr_r;
    if (cmd.ptr_load) begin
      ptr_nxt = ilsu_pkg::addr_t'(idx_r);
    end else if (cmd.ptr_inc) begin
      ptr_nxt = ilsu_pkg::addr_t'(ptr_p1);
    end
  end

  // result value and status
  always_comb begin
    rd_nxt  = rd_r;
    sts_nxt = sts_r;
    if (cmd.rd_capture) begin
      rd_nxt = ram_rdata;
    end else if (cmd.rd_clear) begin
      rd_nxt = '0;
    end
    if (cmd.res_set) begin
      sts_nxt = cmd.res_status;
    end
  end

  // output register
  always_comb begin
    out_nxt = out_r;
    if (cmd.out_load) begin
      out_nxt.read_value = ilsu_pkg::word_t'(rd_r);
      out_nxt.item_count = ilsu_pkg::cnt_fld_t'(count_r);
      out_nxt.status     = sts_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    idx_r <= idx_nxt;
    val_r <= val_nxt;
    ptr_r <= ptr_nxt;
    rd_r  <= rd_nxt;
    sts_r <= sts_nxt;
    out_r <= out_nxt;
  end

  assign out_data = out_r;

  // checks
  `ILSU_ASSERT_SAME(a_shift_in_range, cmd.wr_sel == ilsu_pkg::WR_SHIFT, ptr_p1 < count_r, "shift write past the last item")
  `ILSU_ASSERT_SAME(a_append_room, cmd.wr_sel == ilsu_pkg::WR_APPEND, !stat.full, "append write while full")
  `ILSU_ASSERT_NEXT(a_count_inc, cmd.cnt_inc, count_r == ilsu_pkg::cnt_t'($past(count_r) + 1'b1), "count did not advance after append")

endmodule

// ===== rtl/core/ilsu_ctrl.sv =====
// controller state machine of the list store: sequences each transaction
// depends on ilsu_pkg and the assertion macro header
`include "indexed_list_store_unit_macros.svh"

module ilsu_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  ilsu_pkg::dp_stat_t stat,
  output ilsu_pkg::dp_cmd_t  cmd
);

  ilsu_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             slot_free;

  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = state_r != ilsu_pkg::S_IDLE;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ilsu_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = ilsu_pkg::S_EXEC;
        end
      end
      ilsu_pkg::S_EXEC: begin
        if (stat.command == ilsu_pkg::CMD_APPEND || !stat.idx_ok) begin
          state_nxt = ilsu_pkg::S_DONE;
        end else if (stat.command == ilsu_pkg::CMD_READ) begin
          state_nxt = ilsu_pkg::S_RDWAIT;
        end else if (stat.command == ilsu_pkg::CMD_REMOVE) begin
          state_nxt = ilsu_pkg::S_RMWAIT;
        end else begin
          state_nxt = ilsu_pkg::S_DONE;
        end
      end
      ilsu_pkg::S_RDWAIT: begin
        state_nxt = ilsu_pkg::S_DONE;
      end
      ilsu_pkg::S_RMWAIT: begin
        state_nxt = stat.more1 ? ilsu_pkg::S_SHIFT : ilsu_pkg::S_DONE;
      end
      ilsu_pkg::S_SHIFT: begin
        state_nxt = stat.more2 ? ilsu_pkg::S_SHIFT : ilsu_pkg::S_DONE;
      end
      ilsu_pkg::S_DONE: begin
        if (slot_free) begin
          state_nxt = ilsu_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = ilsu_pkg::S_IDLE;
      end
    endcase
  end

  // datapath commands
  always_comb begin
    cmd = '0;
    case (state_r)
      ilsu_pkg::S_IDLE: begin
        cmd.capture = in_valid;
      end
      ilsu_pkg::S_EXEC: begin
        cmd.res_set = 1'b1;
        cmd.rd_clear = 1'b1;
        cmd.res_status = ilsu_pkg::STS_OK;
        if (stat.command == ilsu_pkg::CMD_APPEND) begin
          if (stat.full) begin
            cmd.res_status = ilsu_pkg::STS_FULL;
          end else begin
            cmd.wr_sel  = ilsu_pkg::WR_APPEND;
            cmd.cnt_inc = 1'b1;
          end
        end else if (!stat.idx_ok) begin
          cmd.res_status = ilsu_pkg::STS_BAD_INDEX;
        end else if (stat.command == ilsu_pkg::CMD_WRITE) begin
          cmd.wr_sel = ilsu_pkg::WR_INDEX;
        end else begin
          cmd.rd_sel   = ilsu_pkg::RD_INDEX;
          cmd.ptr_load = stat.command == ilsu_pkg::CMD_REMOVE;
        end
      end
      ilsu_pkg::S_RDWAIT: begin
        cmd.rd_capture = 1'b1;
      end
      ilsu_pkg::S_RMWAIT: begin
        cmd.rd_capture = 1'b1;
        if (stat.more1) begin
          cmd.rd_sel = ilsu_pkg::RD_PTR1;
        end else begin
          cmd.cnt_dec = 1'b1;
        end
      end
      ilsu_pkg::S_SHIFT: begin
        cmd.wr_sel  = ilsu_pkg::WR_SHIFT;
        cmd.ptr_inc = 1'b1;
        if (stat.more2) begin
          cmd.rd_sel = ilsu_pkg::RD_PTR2;
        end else begin
          cmd.cnt_dec = 1'b1;
        end
      end
      ilsu_pkg::S_DONE: begin
        cmd.out_load = slot_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // result valid
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ilsu_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // checks
  `ILSU_ASSERT_NEXT(a_accept_exec, in_valid && !in_stall, state_r == ilsu_pkg::S_EXEC, "accepted transaction did not start")
  `ILSU_ASSERT_NEXT(a_load_valid, cmd.out_load, out_valid_r && state_r == ilsu_pkg::S_IDLE, "result load did not raise valid")
  `ILSU_ASSERT_NEXT(a_shift_end, state_r == ilsu_pkg::S_SHIFT && !stat.more2, state_r == ilsu_pkg::S_DONE, "shift did not end")

endmodule

// ===== rtl/core/indexed_list_store_unit.sv =====
// top level of the indexed list store unit: controller plus datapath
// depends on ilsu_pkg, ilsu_ctrl and ilsu_datapath
//
//   channel   ports                          payload
//   input     in_valid / in_stall / in_data   command, index, value
//   result    out_valid / out_stall / out_data read_value, item_count, status
//
// one transaction at a time; append, write and failed commands pass the idle,
// execute and done states, read adds a read wait state, remove at index i with
// n items adds a wait state and shifts n - 1 - i items one per cycle in the ram
// the finished result waits in an output register, so out_stall only holds the
// controller in its done state and does not block the datapath before that
// synchronous active-low reset clears the item count; ram contents are not reset
module indexed_list_store_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ilsu_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output ilsu_pkg::out_item_t out_data
);

  ilsu_pkg::dp_cmd_t  dp_cmd;
  ilsu_pkg::dp_stat_t dp_stat;

  // sequencing
  ilsu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (dp_stat),
    .cmd       (dp_cmd)
  );

  // storage and result path
  ilsu_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (dp_cmd),
    .stat     (dp_stat),
    .out_data (out_data)
  );

endmodule
